FILE: design/lrukv_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared widths, command codes, reset values and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lrukv_pkg;

   localparam int DEFAULT_MAX_ENTRIES = 16;
   localparam int CAP_W               = 5;
   localparam int DATA_W              = 32;

   localparam logic [CAP_W-1:0]         CAP_RESET  = CAP_W'(16);
   localparam logic signed [DATA_W-1:0] MISS_VALUE = -DATA_W'(1);
   localparam logic signed [DATA_W-1:0] PUT_VALUE  = '0;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   typedef struct packed {
      logic capture;
      logic search;
      logic find;
      logic commit;
   } lrukv_cmd_type;

   typedef struct packed {
      logic out_free;
   } lrukv_status_type;

endpackage

`default_nettype wire

FILE: design/lrukv_req_if.sv
// ----------------------------------------------------------------------------
// LRU cache request channel
// Valid/ready channel carrying command, key and value.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrukv_req_if import lrukv_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     command;
   logic signed [DATA_W-1:0] key;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output command, output key, output value, input ready);
   modport sink   (input valid, input command, input key, input value, output ready);
endinterface

`default_nettype wire

FILE: design/lrukv_rsp_if.sv
// ----------------------------------------------------------------------------
// LRU cache response channel
// Valid/ready channel carrying hit flag and read value.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrukv_rsp_if import lrukv_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     hit;
   logic signed [DATA_W-1:0] read_value;

   modport source (output valid, output hit, output read_value, input ready);
   modport sink   (input valid, input hit, input read_value, output ready);
endinterface

`default_nettype wire

FILE: design/lru_key_value_cache_top.sv
// Fully associative key-value cache with least-recently-used replacement, holding up to
// MAX_ENTRIES entries in recency order. Each request passes through four steps: accept,
// parallel key compare, first-match select, and commit (shift of the entry row plus load
// of the result register), so a new request is taken only after the previous one
// commits. The result register lets the next request start while a result waits; a commit
// stalls only while the previous result is still held. The user must write capacity
// through the csr port only while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
// LRU key-value cache top level
// Joins the controller and datapath to the request, response and csr ports.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_top import lrukv_pkg::*; #(
   parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
   input  wire logic             clock,
   input  wire logic             reset,
   lrukv_req_if.sink             req,
   lrukv_rsp_if.source           rsp,
   input  wire logic             csr_write_enable,
   input  wire logic [CAP_W-1:0] csr_write_data
);

   lrukv_cmd_type    cmd;
   lrukv_status_type status;

   lrukv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lrukv_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_command      (req.command),
      .req_key          (req.key),
      .req_value        (req.value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp.ready),
      .rsp_valid        (rsp.valid),
      .rsp_hit          (rsp.hit),
      .rsp_read_value   (rsp.read_value)
   );

endmodule

`default_nettype wire

FILE: design/lrukv_ctrl.sv
// ----------------------------------------------------------------------------
// LRU cache controller
// Sequences accept, compare, priority select and commit for each transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module lrukv_ctrl import lrukv_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire lrukv_status_type status,
   output lrukv_cmd_type         cmd
);

   typedef enum logic [1:0] {
      IDLE,
      SEARCH,
      FIND,
      COMMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      case (state_ff)
         IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = SEARCH;
            end
         end
         SEARCH: begin
            cmd.search = 1'b1;
            state_in   = FIND;
         end
         FIND: begin
            cmd.find = 1'b1;
            state_in = COMMIT;
         end
         COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/lrukv_datapath.sv
// ----------------------------------------------------------------------------
// LRU cache datapath
// Recency-ordered entry row, key match, priority select, shift and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrukv_datapath import lrukv_pkg::*; #(
   parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lrukv_cmd_type            cmd,
   output lrukv_status_type              status,
   input  wire logic                     req_command,
   input  wire logic signed [DATA_W-1:0] req_key,
   input  wire logic signed [DATA_W-1:0] req_value,
   input  wire logic                     csr_write_enable,
   input  wire logic [CAP_W-1:0]         csr_write_data,
   input  wire logic                     rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic signed [DATA_W-1:0]      rsp_read_value
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

   logic                     command_ff;
   logic signed [DATA_W-1:0] key_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] keys_ff   [MAX_ENTRIES];
   logic signed [DATA_W-1:0] keys_in   [MAX_ENTRIES];
   logic signed [DATA_W-1:0] values_ff [MAX_ENTRIES];
   logic signed [DATA_W-1:0] values_in [MAX_ENTRIES];
   logic [OCC_W-1:0]         occ_ff;
   logic [OCC_W-1:0]         occ_in;
   logic [CAP_W-1:0]         capacity_ff;
   logic [MAX_ENTRIES-1:0]   match_ff;
   logic [MAX_ENTRIES-1:0]   match_in;
   logic                     hit_ff;
   logic                     hit_in;
   logic [IDX_W-1:0]         pos_ff;
   logic [IDX_W-1:0]         pos_in;
   logic                     rsp_valid_ff;
   logic                     rsp_hit_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic signed [DATA_W-1:0] stored;
   logic signed [DATA_W-1:0] result_value;
   logic [CMP_W-1:0]         cap_ext;
   logic [CMP_W-1:0]         eff_cap;
   logic [CMP_W-1:0]         occ_ext;
   logic [CMP_W-1:0]         shift_n;
   logic                     is_put;
   logic                     update_en;

   assign is_put  = (command_ff == CMD_PUT);
   assign stored  = values_ff[pos_ff];
   assign cap_ext = CMP_W'(capacity_ff);
   assign occ_ext = CMP_W'(occ_ff);

   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match_in[i] = (keys_ff[i] == key_ff) && (OCC_W'(i) < occ_ff);
      end
   end

   always_comb begin
      hit_in = 1'b0;
      pos_in = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_in = 1'b1;
            pos_in = IDX_W'(i);
         end
      end
   end

   always_comb begin
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
         eff_cap = CMP_W'(MAX_ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   always_comb begin
      if (hit_ff) begin
         shift_n = CMP_W'(pos_ff);
      end else if (occ_ext >= eff_cap) begin
         shift_n = eff_cap - CMP_W'(1);
      end else begin
         shift_n = occ_ext;
      end
   end

   assign update_en = cmd.commit && (hit_ff || is_put);

   always_comb begin
      occ_in = occ_ff;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         keys_in[i]   = keys_ff[i];
         values_in[i] = values_ff[i];
      end
      if (update_en) begin
         for (int i = 1; i < MAX_ENTRIES; i++) begin
            if (CMP_W'(i) <= shift_n) begin
               keys_in[i]   = keys_ff[i-1];
               values_in[i] = values_ff[i-1];
            end
         end
         keys_in[0]   = key_ff;
         values_in[0] = is_put ? value_ff : stored;
         if (!hit_ff) begin
            occ_in = OCC_W'(shift_n + CMP_W'(1));
         end
      end
   end

   always_comb begin
      if (is_put) begin
         result_value = PUT_VALUE;
      end else if (hit_ff) begin
         result_value = stored;
      end else begin
         result_value = MISS_VALUE;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         keys_ff[i]   <= keys_in[i];
         values_ff[i] <= values_in[i];
      end
      if (cmd.capture) begin
         command_ff <= req_command;
         key_ff     <= req_key;
         value_ff   <= req_value;
      end
      if (cmd.search) begin
         match_ff <= match_in;
      end
      if (cmd.find) begin
         hit_ff <= hit_in;
         pos_ff <= pos_in;
      end
      if (cmd.commit) begin
         rsp_hit_ff   <= hit_ff;
         rsp_value_ff <= result_value;
      end
   end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives get and put transactions through the request channel and scores each
// response against a recency-ordered shadow store kept alongside the design.
// Directed cases cover empty lookups, extreme keys and values, overwrite,
// eviction, shrinking capacity, and out-of-range capacity settings. These are
// followed by random traffic over small key pools under changing capacities.
// Random gaps are applied on both channels, except in the steady random phases.
// ----------------------------------------------------------------------------
module testbench import lrukv_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH     = DEFAULT_MAX_ENTRIES;
   localparam int RUN_LIMIT = 400000;

   localparam logic [DATA_W-1:0] KEY_LOW  = 32'h8000_0000;
   localparam logic [DATA_W-1:0] KEY_HIGH = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] read_value;
   } lookup_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_write_enable;
   logic [CAP_W-1:0] csr_write_data;

   lrukv_req_if req_if ();
   lrukv_rsp_if rsp_if ();

   lru_key_value_cache_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   logic [DATA_W-1:0] cache_keys   [DEPTH];
   logic [DATA_W-1:0] cache_values [DEPTH];
   int                cache_fill;
   logic [CAP_W-1:0]  cache_capacity;
   lookup_type        pending_lookups [$];
   int                error_count;
   int                cycle_count;
   int                response_stall;
   bit                steady;

   function automatic lookup_type predict_access(logic command, logic [DATA_W-1:0] key,
                                                 logic [DATA_W-1:0] value);
      int                pos;
      int                occ;
      int                limit;
      logic [DATA_W-1:0] stored;
      lookup_type        result;
      pos    = -1;
      occ    = cache_fill;
      stored = '0;
      for (int i = 0; i < occ; i++) begin
         if (pos < 0 && cache_keys[i] == key) begin
            pos = i;
         end
      end
      if (pos >= 0) begin
         stored = cache_values[pos];
         for (int i = pos; i > 0; i--) begin
            cache_keys[i]   = cache_keys[i-1];
            cache_values[i] = cache_values[i-1];
         end
         cache_keys[0]   = key;
         cache_values[0] = (command == CMD_PUT) ? value : stored;
      end else if (command == CMD_PUT) begin
         limit = (cache_capacity == 0) ? 1 : ((cache_capacity > DEPTH) ? DEPTH : cache_capacity);
         if (occ >= limit) begin
            occ = limit - 1;
         end
         for (int i = occ; i > 0; i--) begin
            if (i < DEPTH) begin
               cache_keys[i]   = cache_keys[i-1];
               cache_values[i] = cache_values[i-1];
            end
         end
         cache_keys[0]   = key;
         cache_values[0] = value;
         occ++;
      end
      cache_fill        = occ;
      result.hit        = (pos >= 0);
      result.read_value = (command == CMD_PUT) ? PUT_VALUE : ((pos >= 0) ? stored : MISS_VALUE);
      return result;
   endfunction

   task automatic send_access(logic command, logic [DATA_W-1:0] key, logic [DATA_W-1:0] value);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.command <= command;
      req_if.key     <= key;
      req_if.value   <= value;
      do @(posedge clock); while (!req_if.ready);
      pending_lookups.push_back(predict_access(command, key, value));
   endtask

   task automatic drain_pipeline();
      req_if.valid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] cap);
      drain_pipeline();
      csr_write_data   <= cap;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cache_capacity = cap;
   endtask

   task automatic test_basic_access();
      send_access(CMD_GET, '0, '0);
      send_access(CMD_PUT, KEY_LOW, KEY_HIGH);
      send_access(CMD_PUT, KEY_HIGH, KEY_LOW);
      send_access(CMD_PUT, '0, '0);
      send_access(CMD_PUT, ALL_ONES, ALL_ONES);
      send_access(CMD_GET, KEY_LOW, '0);
      send_access(CMD_GET, ALL_ONES, 32'h1234_5678);
      send_access(CMD_PUT, KEY_LOW, 32'h5A5A_5A5A);
      send_access(CMD_GET, KEY_LOW, ALL_ONES);
   endtask

   task automatic test_eviction();
      write_capacity(CAP_W'(4));
      send_access(CMD_PUT, 32'd5, 32'hA5A5_A5A5);
      send_access(CMD_GET, KEY_HIGH, '0);
   endtask

   task automatic test_capacity_shrink();
      write_capacity(CAP_W'(2));
      send_access(CMD_GET, '0, '0);
      send_access(CMD_PUT, 32'd6, 32'hDEAD_BEEF);
      send_access(CMD_GET, KEY_LOW, '0);
      send_access(CMD_GET, '0, '0);
   endtask

   task automatic test_capacity_limits();
      write_capacity(CAP_W'(0));
      send_access(CMD_PUT, 32'd7, 32'd70);
      send_access(CMD_PUT, 32'd8, 32'd80);
      send_access(CMD_GET, 32'd7, '0);
      send_access(CMD_GET, 32'd8, '0);
      write_capacity(CAP_W'(31));
      for (int i = 0; i < 18; i++) begin
         send_access(CMD_PUT, 32'(100 + i), 32'(i));
      end
      send_access(CMD_GET, 32'd101, '0);
      send_access(CMD_GET, 32'd102, '0);
   endtask

   task automatic test_random_traffic();
      logic [DATA_W-1:0] key_pool [24];
      int                pool_size;
      logic [CAP_W-1:0]  cap;
      logic              command;
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] value;
      for (int phase = 0; phase < 14; phase++) begin
         if (phase == 0) begin
            cap = CAP_W'(1);
         end else if (phase == 1) begin
            cap = CAP_W'(DEPTH);
         end else if ($urandom_range(0, 4) == 0) begin
            cap = CAP_W'($urandom_range(0, 31));
         end else begin
            cap = CAP_W'($urandom_range(1, DEPTH));
         end
         write_capacity(cap);
         steady    = (phase % 3 == 2);
         pool_size = $urandom_range(2, 24);
         for (int i = 0; i < 24; i++) begin
            key_pool[i] = $urandom;
         end
         for (int n = 0; n < 100; n++) begin
            command = $urandom_range(0, 1) ? CMD_PUT : CMD_GET;
            if ($urandom_range(0, 9) == 0) begin
               key = $urandom;
            end else begin
               key = key_pool[$urandom_range(0, pool_size - 1)];
            end
            case ($urandom_range(0, 19))
               0: begin
                  value = KEY_LOW;
               end
               1: begin
                  value = KEY_HIGH;
               end
               2: begin
                  value = ALL_ONES;
               end
               default: begin
                  value = $urandom;
               end
            endcase
            send_access(command, key, value);
            if ($urandom_range(0, 199) == 0) begin
               drain_pipeline();
            end
         end
      end
      steady = 1'b0;
   endtask

   always @(posedge clock) begin : score_responses
      lookup_type want;
      if (reset) begin
         rsp_if.ready   <= 1'b0;
         response_stall = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_lookups.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response hit=%0b read_value=%h", $time,
                        rsp_if.hit, rsp_if.read_value);
            end else begin
               want = pending_lookups.pop_front();
               if (rsp_if.hit !== want.hit) begin
                  error_count++;
                  $display("%0t: hit expected %0b actual %0b", $time, want.hit, rsp_if.hit);
               end
               if (rsp_if.read_value !== want.read_value) begin
                  error_count++;
                  $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                           rsp_if.read_value);
               end
            end
            response_stall = steady ? 0 : $urandom_range(0, 4);
         end else if (response_stall != 0) begin
            response_stall--;
         end
         rsp_if.ready <= (response_stall == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("[lru_key_value_cache_top] ERROR");
         $finish;
      end
   end

   initial begin
      req_if.valid     = 1'b0;
      req_if.command   = CMD_GET;
      req_if.key       = '0;
      req_if.value     = '0;
      rsp_if.ready     = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      cache_fill       = 0;
      cache_capacity   = CAP_RESET;
      error_count      = 0;
      cycle_count      = 0;
      response_stall   = 0;
      steady           = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         cache_keys[i]   = '0;
         cache_values[i] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_basic_access();
      test_eviction();
      test_capacity_shrink();
      test_capacity_limits();
      test_random_traffic();
      drain_pipeline();
      if (error_count == 0) begin
         $display("[lru_key_value_cache_top] OK");
      end else begin
         $display("[lru_key_value_cache_top] ERROR");
      end
      $finish;
   end
endmodule
